### hw/rtl/mdr_pkg.sv
// mdr_pkg: shared types and constants for the multiply/divide register unit
// used by mdr_ctrl, mdr_dp and mul_div_register_unit; no dependencies
`default_nettype none

package mdr_pkg;

  // request operation codes
  typedef enum logic [0:0] {
    OP_WRITE = 1'b0,
    OP_READ  = 1'b1
  } opcode_e;

  // byte register map
  localparam logic [3:0] REG_OPA_B0 = 4'd0;
  localparam logic [3:0] REG_OPA_B1 = 4'd1;
  localparam logic [3:0] REG_OPA_B2 = 4'd2;
  localparam logic [3:0] REG_OPA_B3 = 4'd3;
  localparam logic [3:0] REG_MPY_LO = 4'd4;
  localparam logic [3:0] REG_MPY_HI = 4'd5;
  localparam logic [3:0] REG_DVS_LO = 4'd6;
  localparam logic [3:0] REG_DVS_HI = 4'd7;
  localparam logic [3:0] REG_RES_B0 = 4'd8;
  localparam logic [3:0] REG_RES_B3 = 4'd11;
  localparam logic [3:0] REG_REM_LO = 4'd12;
  localparam logic [3:0] REG_REM_HI = 4'd13;
  localparam logic [3:0] REG_MODE   = 4'd14;
  localparam logic [3:0] REG_STATUS = 4'd15;

  // divider iteration count, one quotient bit per step
  localparam int unsigned DIV_STEPS = 32;
  localparam int unsigned CNT_W     = $clog2(DIV_STEPS);

  // controller states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_DIV_LOAD,
    ST_DIV_STEP,
    ST_DIV_FIX
  } state_e;

  // controller to datapath commands
  typedef struct packed {
    logic take;      // request accepted this cycle
    logic mul_exec;  // compute product into result
    logic div_load;  // load magnitudes, handle zero divisor
    logic div_step;  // one restoring divide step
    logic div_fix;   // apply signs, write quotient and remainder
  } cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic req_mul;   // pending request starts a multiply
    logic req_div;   // pending request starts a divide
    logic div_zero;  // divisor register is zero
    logic mul_done;  // sticky multiply done flag
  } sts_t;

endpackage

`default_nettype wire

### hw/rtl/mdr_ctrl.sv
// mdr_ctrl: sequencing state machine, request handshake and result valid
// depends on mdr_pkg
`default_nettype none

module mdr_ctrl (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         in_valid_i,
  output logic              in_ready_o,
  output logic              out_valid_o,
  input  wire logic         out_ready_i,
  input  wire mdr_pkg::sts_t sts_i,
  output mdr_pkg::cmd_t     cmd_o
);
  import mdr_pkg::*;

  state_e           state_q, state_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             out_valid_q, out_valid_d;

  // state, step counter and result valid registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  // next state and commands
  always_comb begin
    state_d    = state_q;
    cnt_d      = cnt_q;
    in_ready_o = 1'b0;
    cmd_o      = '0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o = !out_valid_q || out_ready_i;
        if (in_valid_i && in_ready_o) begin
          cmd_o.take = 1'b1;
          if (sts_i.req_mul) begin
            state_d = ST_MUL;
          end else if (sts_i.req_div) begin
            state_d = ST_DIV_LOAD;
          end
        end
      end
      ST_MUL: begin
        cmd_o.mul_exec = 1'b1;
        state_d        = ST_IDLE;
      end
      ST_DIV_LOAD: begin
        cmd_o.div_load = 1'b1;
        cnt_d          = '0;
        state_d        = sts_i.div_zero ? ST_IDLE : ST_DIV_STEP;
      end
      ST_DIV_STEP: begin
        cmd_o.div_step = 1'b1;
        cnt_d          = cnt_q + CNT_W'(1);
        if (cnt_q == CNT_W'(DIV_STEPS - 1)) begin
          state_d = ST_DIV_FIX;
        end
      end
      ST_DIV_FIX: begin
        cmd_o.div_fix = 1'b1;
        state_d       = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // result valid: set on accept, cleared when taken
  always_comb begin
    out_valid_d = out_valid_q;
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end
    if (cmd_o.take) begin
      out_valid_d = 1'b1;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

`default_nettype wire

### hw/rtl/mdr_dp.sv
// mdr_dp: register file, 17x17 multiplier, radix-2 divider and read mux
// depends on mdr_pkg
`default_nettype none

module mdr_dp (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          opcode_i,
  input  wire logic [3:0]    register_index_i,
  input  wire logic [7:0]    write_data_i,
  input  wire mdr_pkg::cmd_t cmd_i,
  output mdr_pkg::sts_t      sts_o,
  output logic [7:0]         read_data_o
);
  import mdr_pkg::*;

  // architectural registers
  logic [31:0] opa_q;
  logic [15:0] mpy_q;
  logic [15:0] dvs_q;
  logic [31:0] res_q;
  logic [15:0] rem_q;
  logic        mode_q;
  logic        done_q;

  // divider working registers
  logic [31:0] quo_q;
  logic [15:0] wrem_q;
  logic [15:0] wdvs_q;
  logic        negq_q;
  logic        negr_q;
  logic [7:0]  rdata_q;

  logic               is_write;
  logic signed [16:0] mul_a, mul_b;
  logic signed [33:0] prod;
  logic               dvd_neg, dvs_neg;
  logic [31:0]        dvd_abs;
  logic [15:0]        dvs_abs;
  logic [16:0]        shifted;
  logic [17:0]        diff;
  logic [7:0]         rbyte;

  assign is_write = (opcode_i == OP_WRITE);

  // request decode for the controller
  assign sts_o.req_mul  = is_write && (register_index_i == REG_MPY_HI);
  assign sts_o.req_div  = is_write && (register_index_i == REG_DVS_HI);
  assign sts_o.div_zero = (dvs_q == 16'd0);
  assign sts_o.mul_done = done_q;

  // multiplier operands, sign or zero extended by mode
  assign mul_a = {mode_q & opa_q[15], opa_q[15:0]};
  assign mul_b = {mode_q & mpy_q[15], mpy_q};
  assign prod  = mul_a * mul_b;

  // operand magnitudes for the divider
  assign dvd_neg = mode_q & opa_q[31];
  assign dvs_neg = mode_q & dvs_q[15];
  assign dvd_abs = dvd_neg ? (32'd0 - opa_q) : opa_q;
  assign dvs_abs = dvs_neg ? (16'd0 - dvs_q) : dvs_q;

  // restoring divide step
  assign shifted = {wrem_q, quo_q[31]};
  assign diff    = {1'b0, shifted} - {2'b00, wdvs_q};

  // architectural register updates
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      opa_q  <= '0;
      mpy_q  <= '0;
      dvs_q  <= '0;
      res_q  <= '0;
      rem_q  <= '0;
      mode_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      if (cmd_i.take && is_write) begin
        case (register_index_i)
          REG_OPA_B0, REG_OPA_B1, REG_OPA_B2, REG_OPA_B3: begin
            opa_q[{register_index_i[1:0], 3'b000} +: 8] <= write_data_i;
          end
          REG_MPY_LO: mpy_q[7:0]  <= write_data_i;
          REG_MPY_HI: mpy_q[15:8] <= write_data_i;
          REG_DVS_LO: dvs_q[7:0]  <= write_data_i;
          REG_DVS_HI: dvs_q[15:8] <= write_data_i;
          REG_MODE:   mode_q      <= write_data_i[0];
          default: begin
          end
        endcase
      end
      if (cmd_i.mul_exec) begin
        res_q  <= prod[31:0];
        done_q <= 1'b1;
      end
      if (cmd_i.div_load && sts_o.div_zero) begin
        res_q <= '0;
        rem_q <= opa_q[15:0];
      end
      if (cmd_i.div_fix) begin
        res_q <= negq_q ? (32'd0 - quo_q) : quo_q;
        rem_q <= negr_q ? (16'd0 - wrem_q) : wrem_q;
      end
    end
  end

  // divider working registers and read data
  always_ff @(posedge clk_i) begin
    if (cmd_i.div_load) begin
      quo_q  <= dvd_abs;
      wrem_q <= '0;
      wdvs_q <= dvs_abs;
      negq_q <= dvd_neg ^ dvs_neg;
      negr_q <= dvd_neg;
    end else if (cmd_i.div_step) begin
      if (!diff[17]) begin
        wrem_q <= diff[15:0];
        quo_q  <= {quo_q[30:0], 1'b1};
      end else begin
        wrem_q <= shifted[15:0];
        quo_q  <= {quo_q[30:0], 1'b0};
      end
    end
    if (cmd_i.take) begin
      rdata_q <= is_write ? 8'd0 : rbyte;
    end
  end

  // register read mux
  always_comb begin
    case (register_index_i) inside
      [REG_OPA_B0:REG_OPA_B3]: rbyte = opa_q[{register_index_i[1:0], 3'b000} +: 8];
      [REG_MPY_LO:REG_MPY_HI]: rbyte = mpy_q[{register_index_i[0], 3'b000} +: 8];
      [REG_DVS_LO:REG_DVS_HI]: rbyte = dvs_q[{register_index_i[0], 3'b000} +: 8];
      [REG_RES_B0:REG_RES_B3]: rbyte = res_q[{register_index_i[1:0], 3'b000} +: 8];
      [REG_REM_LO:REG_REM_HI]: rbyte = rem_q[{register_index_i[0], 3'b000} +: 8];
      REG_MODE:                rbyte = {7'd0, mode_q};
      REG_STATUS:              rbyte = {7'd0, done_q};
      default:                 rbyte = 8'd0;
    endcase
  end

  assign read_data_o = rdata_q;

endmodule

`default_nettype wire

### hw/rtl/mul_div_register_unit.sv
// mul_div_register_unit: top level, byte register block with multiply and divide
// depends on mdr_pkg, mdr_ctrl, mdr_dp
//
//  channel   dir  handshake                 payload
//  request   in   in_valid_i / in_ready_o   opcode_i, register_index_i, write_data_i
//  response  out  out_valid_o / out_ready_i read_data_o
//
// register reads and plain writes keep the state machine idle; a multiplier high
// byte write also runs the multiply state; a divisor high byte write runs
// load, 32 restoring divider steps and sign fix, or load only on a zero divisor.
// the response is registered at accept; a pending response holds off the next request.
// asynchronous active-low reset clears the control state and architectural registers.
`default_nettype none

module mul_div_register_unit (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       in_valid_i,
  output logic            in_ready_o,
  input  wire logic       opcode_i,
  input  wire logic [3:0] register_index_i,
  input  wire logic [7:0] write_data_i,
  output logic            out_valid_o,
  input  wire logic       out_ready_i,
  output logic [7:0]      read_data_o
);
  import mdr_pkg::*;

  cmd_t cmd;
  sts_t sts;

  // sequencing
  mdr_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  // registers and arithmetic
  mdr_dp u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .opcode_i         (opcode_i),
    .register_index_i (register_index_i),
    .write_data_i     (write_data_i),
    .cmd_i            (cmd),
    .sts_o            (sts),
    .read_data_o      (read_data_o)
  );

`ifndef SYNTHESIS
  // starting a divide blocks the next request
  a_div_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && (opcode_i == OP_WRITE) && (register_index_i == REG_DVS_HI)
    |=> !in_ready_o)
    else $error("request accepted while divide in progress");

  // a write request answers with zero data
  a_write_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && (opcode_i == OP_WRITE)
    |=> out_valid_o && (read_data_o == 8'd0))
    else $error("write request response not zero");

  // multiply done flag is sticky
  a_done_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sts.mul_done |=> sts.mul_done)
    else $error("multiply done flag cleared");

  // commands are issued only one at a time
  a_cmd_onehot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0(cmd))
    else $error("more than one datapath command active");
`endif

endmodule

`default_nettype wire
